// ===== rtl/vefind_pkg.sv =====
`default_nettype none

package vefind_pkg;

  // Request kinds on the input channel
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_SELECT = 2'd3;

  // Field widths of the channels
  localparam int COORD_W = 6;
  localparam int MASK_W  = 4;
  localparam int DIM_W   = 7;
  localparam int SEL_W   = 2;

  // Face codes, in emission order
  localparam logic [2:0] FACE_NEG_Z = 3'd0;
  localparam logic [2:0] FACE_POS_Z = 3'd1;
  localparam logic [2:0] FACE_NEG_X = 3'd2;
  localparam logic [2:0] FACE_POS_X = 3'd3;
  localparam logic [2:0] FACE_NEG_Y = 3'd4;
  localparam logic [2:0] FACE_POS_Y = 3'd5;

  localparam int FACE_COUNT = 6;

  typedef logic [2:0] face_code_t;

endpackage

`default_nettype wire

// ===== rtl/voxel_exposed_face_finder_top.sv =====
`default_nettype none

// Voxel exposed-face finder.
// Input channel (in_valid / in_stall) carries requests: a write request sets the
// label mask of one cell, a query request asks for the exposed faces of one cell.
// Output channel (out_valid / out_stall) carries one face record per exposed face
// of a solid queried cell, in the order -z, +z, -x, +x, -y, +y; last_face marks
// the final record of a query. A query on a non-solid or out-of-grid cell, or one
// with no exposed face, gives no record. Writes give no record.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written by the user only
// while idle; the block itself does not enforce this. A write request is stored in
// the label memory as it is accepted. A query reads the cell and its six neighbors
// one after another through the single port of the label memory: an accept step,
// the probe state and a decide state, then one record per cycle while the receiver takes them.
// A query on a cell outside the grid in use is dropped when it is accepted.
// A waiting record sits in the output register; in_stall falls as soon as the last
// record is loaded there, so the next request may enter while it still waits.
// Reset: rst clears the control state, then a clearing pass zeroes the label memory,
// one cell per cycle over all 2**(3*clog2(AXIS_CELLS)) cells (262144 at 64 per axis);
// in_stall stays high for that pass. Configuration writes are taken always.
module voxel_exposed_face_finder_top #(
  parameter int AXIS_CELLS  = 64,
  parameter int LABEL_COUNT = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration port
  input  wire logic                                   cfg_we,
  input  wire logic [vefind_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vefind_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   kind,
  input  wire logic [vefind_pkg::COORD_W-1:0]         cell_x,
  input  wire logic [vefind_pkg::COORD_W-1:0]         cell_y,
  input  wire logic [vefind_pkg::COORD_W-1:0]         cell_z,
  input  wire logic [vefind_pkg::MASK_W-1:0]          label_mask,
  // face record channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [vefind_pkg::COORD_W-1:0]              face_x,
  output logic [vefind_pkg::COORD_W-1:0]              face_y,
  output logic [vefind_pkg::COORD_W-1:0]              face_z,
  output vefind_pkg::face_code_t                      face_code,
  output logic                                        last_face
);
  import vefind_pkg::*;

  // Cell address is {y, z, x}, each CW bits wide
  localparam int CW    = $clog2(AXIS_CELLS);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 2 ** AW;
  // Compare width: holds a saturated grid size and a 7-bit register value
  localparam int DW    = $clog2(AXIS_CELLS + 1);
  localparam int CMPW  = (DW > DIM_W) ? DW : DIM_W;
  localparam int LW    = (LABEL_COUNT > MASK_W) ? LABEL_COUNT : MASK_W;
  localparam logic [CMPW-1:0] ONE      = CMPW'(1);
  localparam logic [CMPW-1:0] AXIS_MAX = CMPW'(AXIS_CELLS);
  localparam logic [2:0] PROBE_LAST = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_length;
  logic [DIM_W-1:0] grid_height;
  logic [SEL_W-1:0] label_select;

  // sequencer registers
  logic [AW-1:0]           clr_addr;
  logic [COORD_W-1:0]      qx;
  logic [COORD_W-1:0]      qy;
  logic [COORD_W-1:0]      qz;
  logic [2:0]              probe;
  logic [FACE_COUNT:0]     solid;   // bit 0 center, bit f+1 neighbor of face f
  logic [FACE_COUNT-1:0]   faces;   // exposed faces still to emit

  // label memory
  logic [LABEL_COUNT-1:0]  mem [DEPTH];
  logic [LABEL_COUNT-1:0]  rdata;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we;
  logic [LABEL_COUNT-1:0]  mem_wdata;

  // combinational helpers
  logic                    accept;
  logic                    load;
  logic [CMPW-1:0]         dim_w;
  logic [CMPW-1:0]         dim_l;
  logic [CMPW-1:0]         dim_h;
  logic [CMPW-1:0]         cx;
  logic [CMPW-1:0]         cy;
  logic [CMPW-1:0]         cz;
  logic [CMPW-1:0]         px;
  logic [CMPW-1:0]         py;
  logic [CMPW-1:0]         pz;
  logic [CMPW-1:0]         ax;
  logic [CMPW-1:0]         ay;
  logic [CMPW-1:0]         az;
  logic                    in_store;
  logic                    in_grid;
  logic                    rd_solid;
  logic [LW-1:0]           mask_wide;
  logic [FACE_COUNT-1:0]   exposed;
  face_code_t              pick;
  logic [FACE_COUNT-1:0]   rest;

  function automatic logic [CMPW-1:0] sat_dim(input logic [DIM_W-1:0] d);
    logic [CMPW-1:0] dz;
    dz = CMPW'(d);
    if (dz == '0) begin
      return ONE;
    end else if (dz > AXIS_MAX) begin
      return AXIS_MAX;
    end
    return dz;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = !out_valid || !out_stall;

  assign dim_w = sat_dim(grid_width);
  assign dim_l = sat_dim(grid_length);
  assign dim_h = sat_dim(grid_height);

  assign cx = CMPW'(cell_x);
  assign cy = CMPW'(cell_y);
  assign cz = CMPW'(cell_z);
  assign px = CMPW'(qx);
  assign py = CMPW'(qy);
  assign pz = CMPW'(qz);

  assign in_store = (cx < AXIS_MAX) && (cy < AXIS_MAX) && (cz < AXIS_MAX);
  assign in_grid  = (cx < dim_w) && (cy < dim_h) && (cz < dim_l);

  // Keep the mask bits that fit the label count, zero any extra label bits
  assign mask_wide = LW'(label_mask);

  // Probe address: center first, then the neighbors in face order.
  // Border neighbors may wrap; their result is masked in the decide step.
  always_comb begin
    ax = px;
    ay = py;
    az = pz;
    unique case (probe)
      3'd1:    az = pz - ONE;
      3'd2:    az = pz + ONE;
      3'd3:    ax = px - ONE;
      3'd4:    ax = px + ONE;
      3'd5:    ay = py - ONE;
      3'd6:    ay = py + ONE;
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = mask_wide[LABEL_COUNT-1:0];
    mem_addr  = {CW'(ay), CW'(az), CW'(ax)};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
      mem_addr  = clr_addr;
    end else if (accept && (kind == KIND_WRITE)) begin
      mem_we   = in_store;
      mem_addr = {CW'(cy), CW'(cz), CW'(cx)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Selected label bit of the word read last cycle; none if select is past the labels
  always_comb begin
    rd_solid = 1'b0;
    for (int i = 0; i < LABEL_COUNT; i++) begin
      if (i == int'(label_select)) begin
        rd_solid = rdata[i];
      end
    end
  end

  always_comb begin
    exposed[FACE_NEG_Z] = (pz == '0) || !solid[1];
    exposed[FACE_POS_Z] = (pz >= dim_l - ONE) || !solid[2];
    exposed[FACE_NEG_X] = (px == '0) || !solid[3];
    exposed[FACE_POS_X] = (px >= dim_w - ONE) || !solid[4];
    exposed[FACE_NEG_Y] = (py == '0) || !solid[5];
    exposed[FACE_POS_Y] = (py >= dim_h - ONE) || !solid[6];
  end

  // Lowest remaining face goes out next
  always_comb begin
    pick = FACE_NEG_Z;
    for (int f = FACE_COUNT - 1; f >= 0; f--) begin
      if (faces[f]) begin
        pick = face_code_t'(f);
      end
    end
    rest       = faces;
    rest[pick] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      grid_width   <= DIM_W'(64);
      grid_length  <= DIM_W'(64);
      grid_height  <= DIM_W'(64);
      label_select <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:   grid_width   <= cfg_data;
          REG_GRID_LENGTH:  grid_length  <= cfg_data;
          REG_GRID_HEIGHT:  grid_height  <= cfg_data;
          REG_LABEL_SELECT: label_select <= cfg_data[SEL_W-1:0];
        endcase
      end

      // drop a record once the receiver takes it
      if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (kind == KIND_QUERY)) begin
            qx    <= cell_x;
            qy    <= cell_y;
            qz    <= cell_z;
            probe <= '0;
            if (in_grid) begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          // read data is registered, so it belongs to the previous probe address
          if (probe != '0) begin
            solid[probe - 3'd1] <= rd_solid;
          end
          probe <= probe + 3'd1;
          if (probe == PROBE_LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          faces <= exposed;
          if (solid[0] && (exposed != '0)) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            face_x    <= qx;
            face_y    <= qy;
            face_z    <= qz;
            face_code <= pick;
            last_face <= (rest == '0);
            faces     <= rest;
            if (rest == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vefind_checker.sv =====
`default_nettype none

module vefind_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] face_x,
  input wire logic [5:0] face_y,
  input wire logic [5:0] face_z,
  input wire logic [2:0] face_code,
  input wire logic       last_face
);

  // A stalled record stays valid and keeps its face code, face_x and last_face
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(face_code) && $stable(face_x)
      && $stable(last_face))
    else $error("stalled face record changed");

  // The memory clearing pass blocks requests right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("request channel open during clearing pass");

  // A taken record that is not the last is followed at once by a later face of the same cell
  a_next_face: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_face |=>
      out_valid && (face_code > $past(face_code)) && (face_x == $past(face_x))
      && (face_y == $past(face_y)) && (face_z == $past(face_z)))
    else $error("face records of a query out of order");

  // No new request while a query still has records to send
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_face |-> in_stall)
    else $error("request accepted in the middle of a query");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("face record valid after reset");

endmodule

bind voxel_exposed_face_finder_top vefind_checker u_vefind_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .face_x    (face_x),
  .face_y    (face_y),
  .face_z    (face_z),
  .face_code (face_code),
  .last_face (last_face)
);

`default_nettype wire
